/* hw/rtl/aba_pkg.sv */
// aba_pkg: operation, status and register index codes for the aligned bump allocator
// used by aligned_bump_allocator_top; depends on nothing
`timescale 1ns / 1ps

package aba_pkg;

  typedef enum logic [2:0] {
    OP_ALLOC   = 3'd0,
    OP_RESERVE = 3'd1,
    OP_COMMIT  = 3'd2,
    OP_CANCEL  = 3'd3,
    OP_RESET   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_OPEN     = 2'd2,
    ST_OVERSIZE = 2'd3
  } status_t;

  typedef enum logic {
    REG_BASE  = 1'b0,
    REG_BYTES = 1'b1
  } reg_idx_t;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned ALIGN_W = 5;

endpackage

/* hw/rtl/aligned_bump_allocator_top.sv */
// aligned_bump_allocator_top: bump-pointer allocator over one configured region
// depends on aba_pkg
`timescale 1ns / 1ps
// Usage:
//   in_*  : request words. in_tuser carries the operation (allocate, reserve,
//           commit, cancel, reset arena), in_tdata the byte count and alignment.
//   out_* : one result word per request: aligned address in out_tdata, status
//           in out_tuser.
//   cfg_* : register writes (region base, size), always ready; the user must
//           write them only while no request is in flight; the block does not check.
// Each request is captured in the input register; the compute step then
// updates the used count and reservation and loads the result register. One
// word per cycle is sustained while out_tready stays high; the rate is set by
// the used-count update that each request reads back in the next cycle.
// Reset clears the used count, the open reservation, both region registers and
// all valid flags. While the receiver holds out_tready low the result holds,
// the input register fills and then in_tready drops; nothing is lost.

module aligned_bump_allocator_top
  import aba_pkg::*;
#(
  parameter int unsigned ADDR_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // request_bytes[31:0], align_log2[36:32], zero fill
  input  logic [2:0]  in_tuser,   // op[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // block_address[31:0]
  output logic [1:0]  out_tuser,  // status[1:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int unsigned LIMIT_BITS = (ADDR_BITS < WORD_W) ? ADDR_BITS : WORD_W;

  logic [WORD_W-1:0]  base_r, rbytes_r;
  logic [WORD_W-1:0]  used_r, used_nxt;
  logic [WORD_W-1:0]  pad_r, pad_nxt;
  logic [WORD_W-1:0]  span_r, span_nxt;

  logic               s1_valid_r;
  logic [2:0]         s1_op_r;
  logic [WORD_W-1:0]  s1_req_r;
  logic [ALIGN_W-1:0] s1_lg_r;

  logic               out_valid_r;
  logic [WORD_W-1:0]  out_addr_r, out_addr_nxt;
  status_t            out_status_r, out_status_nxt;

  logic               s1_fire;
  logic [WORD_W:0]    start;
  logic [WORD_W-1:0]  align_mask;
  logic [WORD_W-1:0]  fit_pad;
  logic [WORD_W+1:0]  aligned;
  logic [WORD_W+1:0]  fit_need;
  logic               fit_ok;
  logic [WORD_W-1:0]  payload;
  logic [WORD_W+1:0]  commit_need;
  logic               res_open;

  assign cfg_ready  = 1'b1;
  assign s1_fire    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || s1_fire;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_addr_r;
  assign out_tuser  = out_status_r;

  // alignment padding, fit check and reservation state
  always_comb begin
    start       = {1'b0, base_r} + {1'b0, used_r};
    align_mask  = ~({WORD_W{1'b1}} << s1_lg_r);
    fit_pad     = (~start[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, 1'b1}) & align_mask;
    aligned     = {1'b0, start} + {2'b00, fit_pad};
    fit_need    = {2'b00, used_r} + {2'b00, s1_req_r} + {2'b00, fit_pad};
    fit_ok      = (fit_need <= {2'b00, rbytes_r}) && !(|aligned[WORD_W+1:LIMIT_BITS]);
    payload     = (span_r >= pad_r) ? (span_r - pad_r) : '0;
    commit_need = {2'b00, used_r} + {2'b00, pad_r} + {2'b00, s1_req_r};
    res_open    = (pad_r != '0) || (span_r != '0);
  end

  always_comb begin
    used_nxt       = used_r;
    pad_nxt        = pad_r;
    span_nxt       = span_r;
    out_addr_nxt   = '0;
    out_status_nxt = ST_OK;
    case (op_t'(s1_op_r))
      OP_ALLOC: begin
        if (fit_ok) begin
          used_nxt     = fit_need[WORD_W-1:0];
          out_addr_nxt = aligned[WORD_W-1:0];
        end else begin
          out_status_nxt = ST_NO_SPACE;
        end
      end
      OP_RESERVE: begin
        if (res_open) begin
          out_status_nxt = ST_OPEN;
        end else if (fit_ok) begin
          pad_nxt      = fit_pad;
          span_nxt     = s1_req_r + fit_pad;
          out_addr_nxt = aligned[WORD_W-1:0];
        end else begin
          out_status_nxt = ST_NO_SPACE;
        end
      end
      OP_COMMIT: begin
        if (s1_req_r != '0) begin
          if (s1_req_r > payload) begin
            out_status_nxt = ST_OVERSIZE;
          end else if (commit_need > {2'b00, rbytes_r}) begin
            out_status_nxt = ST_NO_SPACE;
          end else begin
            used_nxt = commit_need[WORD_W-1:0];
          end
        end
        pad_nxt  = '0;
        span_nxt = '0;
      end
      OP_CANCEL: begin
        pad_nxt  = '0;
        span_nxt = '0;
      end
      OP_RESET: begin
        used_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r       <= '0;
      rbytes_r     <= '0;
      used_r       <= '0;
      pad_r        <= '0;
      span_r       <= '0;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      out_status_r <= ST_OK;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_BASE:  base_r   <= cfg_data;
          REG_BYTES: rbytes_r <= cfg_data;
          default: begin
          end
        endcase
      end
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (s1_fire) begin
        used_r       <= used_nxt;
        pad_r        <= pad_nxt;
        span_r       <= span_nxt;
        out_valid_r  <= 1'b1;
        out_status_r <= out_status_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_op_r  <= in_tuser;
      s1_req_r <= in_tdata[31:0];
      s1_lg_r  <= in_tdata[36:32];
    end
    if (s1_fire) begin
      out_addr_r <= out_addr_nxt;
    end
  end

  a_addr_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_addr_r != '0) |-> out_status_r == ST_OK)
    else $error("nonzero address with failing status");

  a_span_covers_pad: assert property (@(posedge clk) disable iff (!rst_n)
    pad_r <= span_r)
    else $error("reservation span below its padding");

  a_commit_closes: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && (s1_op_r == OP_COMMIT || s1_op_r == OP_CANCEL)
      |=> pad_r == '0 && span_r == '0)
    else $error("reservation still open after commit or cancel");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_fire |=> s1_valid_r && $stable(s1_req_r) && $stable(s1_op_r))
    else $error("input stage lost a stalled request");

endmodule
